// File: sv/vt4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_pkg
// Shared types and constants for the 4x4 vertex transform.
// ----------------------------------------------------------------------------
package vt4_pkg;

	typedef logic signed [15:0] coef_t;
	typedef logic signed [31:0] comp_t;
	typedef logic signed [47:0] prod_t;
	typedef logic signed [35:0] trunc_t;
	typedef logic signed [36:0] pair_t;
	typedef logic signed [37:0] sum_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

	localparam int unsigned FRAC_DROP = 12;

	localparam logic [2:0] REG_ROW0      = 3'd0;
	localparam logic [2:0] REG_ROW1      = 3'd1;
	localparam logic [2:0] REG_ROW2      = 3'd2;
	localparam logic [2:0] REG_ROW3      = 3'd3;
	localparam logic [2:0] REG_TRANSPOSE = 3'd4;

	localparam logic [63:0] ROW0_RESET = 64'h0000_0000_0000_1000;
	localparam logic [63:0] ROW1_RESET = 64'h0000_0000_1000_0000;
	localparam logic [63:0] ROW2_RESET = 64'h0000_1000_0000_0000;
	localparam logic [63:0] ROW3_RESET = 64'h1000_0000_0000_0000;

	localparam sum_t SUM_MAX = 38'sh00_7FFF_FFFF;
	localparam sum_t SUM_MIN = 38'sh3F_8000_0000;

	localparam comp_t COMP_MAX = 32'sh7FFF_FFFF;
	localparam comp_t COMP_MIN = 32'sh8000_0000;

endpackage

// File: sv/vt4_dot4.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_dot4
// Three-stage dot product of four Q4.12 coefficients with a Q16.16 vertex:
// multiply and truncate, add pairs, add and saturate.
// ----------------------------------------------------------------------------
module vt4_dot4 (
	input  logic                clk,
	input  vt4_pkg::stage_en_t  en,
	input  vt4_pkg::coef_t      coef [4],
	input  vt4_pkg::comp_t      vtx  [4],
	output vt4_pkg::comp_t      result_s3,
	output logic                sat_s3
);

	vt4_pkg::prod_t  prod     [4];
	vt4_pkg::trunc_t trunc_s1 [4];
	vt4_pkg::pair_t  pair_s2  [2];
	vt4_pkg::sum_t   sum;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			prod[j] = vt4_pkg::prod_t'(coef[j]) * vt4_pkg::prod_t'(vtx[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int j = 0; j < 4; j++) begin
				trunc_s1[j] <= prod[j][47:vt4_pkg::FRAC_DROP];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			pair_s2[0] <= vt4_pkg::pair_t'(trunc_s1[0]) + vt4_pkg::pair_t'(trunc_s1[1]);
			pair_s2[1] <= vt4_pkg::pair_t'(trunc_s1[2]) + vt4_pkg::pair_t'(trunc_s1[3]);
		end
	end

	assign sum = vt4_pkg::sum_t'(pair_s2[0]) + vt4_pkg::sum_t'(pair_s2[1]);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			if (sum > vt4_pkg::SUM_MAX) begin
				result_s3 <= vt4_pkg::COMP_MAX;
				sat_s3    <= 1'b1;
			end else if (sum < vt4_pkg::SUM_MIN) begin
				result_s3 <= vt4_pkg::COMP_MIN;
				sat_s3    <= 1'b1;
			end else begin
				result_s3 <= sum[31:0];
				sat_s3    <= 1'b0;
			end
		end
	end

endmodule

// File: sv/vertex_transform_4x4.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_4x4
// Homogeneous vertex transform by a loaded 4x4 Q4.12 matrix.
// ----------------------------------------------------------------------------
// Software writes the four matrix rows and the transpose flag through the
// cfg port while the block is idle. Each row packs four signed Q4.12
// coefficients, column j at bits 16j. After reset the matrix is identity and
// the transpose flag is clear.
// Each item on the s_axis channel is one vertex of four signed Q16.16
// components; each item on the m_axis channel is the transformed vertex,
// with tuser set when any component was clamped to the 32-bit range.
// The datapath is three register stages: sixteen 16x32 multiplies with
// truncation, pairwise adds, and the final add with saturation. The third
// stage is the output register: an accepted vertex moves through stage 1
// and stage 2 into it, and m_axis_tvalid marks it as holding a result.
// Throughput is one item per cycle while the receiver is ready. When it
// stalls, the stages fill up behind the output register and s_axis_tready
// drops only once every stage holds an item; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module vertex_transform_4x4 (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [63:0]   cfg_wdata,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// vertex_x [31:0], vertex_y [63:32], vertex_z [95:64], vertex_w [127:96]
	input  logic [127:0]  s_axis_tdata,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// out_x [31:0], out_y [63:32], out_z [95:64], out_w [127:96]
	output logic [127:0]  m_axis_tdata,
	// saturated [0]
	output logic          m_axis_tuser
);

	logic [63:0] row_q [4];
	logic        transpose_q;

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	vt4_pkg::stage_en_t en;

	vt4_pkg::comp_t vtx [4];
	vt4_pkg::comp_t res_s3 [4];
	logic [3:0]     sat_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0]    <= vt4_pkg::ROW0_RESET;
			row_q[1]    <= vt4_pkg::ROW1_RESET;
			row_q[2]    <= vt4_pkg::ROW2_RESET;
			row_q[3]    <= vt4_pkg::ROW3_RESET;
			transpose_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				vt4_pkg::REG_ROW0:      row_q[0]    <= cfg_wdata;
				vt4_pkg::REG_ROW1:      row_q[1]    <= cfg_wdata;
				vt4_pkg::REG_ROW2:      row_q[2]    <= cfg_wdata;
				vt4_pkg::REG_ROW3:      row_q[3]    <= cfg_wdata;
				vt4_pkg::REG_TRANSPOSE: transpose_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign rdy_s3 = !v_s3 || m_axis_tready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	assign en.s1 = rdy_s1;
	assign en.s2 = rdy_s2;
	assign en.s3 = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	genvar gi, gj;
	generate
		for (gj = 0; gj < 4; gj++) begin : g_vtx
			assign vtx[gj] = s_axis_tdata[32*gj +: 32];
		end

		for (gi = 0; gi < 4; gi++) begin : g_row
			vt4_pkg::coef_t coef [4];

			for (gj = 0; gj < 4; gj++) begin : g_col
				assign coef[gj] = transpose_q ? row_q[gj][16*gi +: 16]
				                              : row_q[gi][16*gj +: 16];
			end

			vt4_dot4 u_dot (
				.clk       (clk),
				.en        (en),
				.coef      (coef),
				.vtx       (vtx),
				.result_s3 (res_s3[gi]),
				.sat_s3    (sat_s3[gi])
			);

			assign m_axis_tdata[32*gi +: 32] = res_s3[gi];
		end
	endgenerate

	assign m_axis_tvalid = v_s3;
	assign m_axis_tuser  = |sat_s3;

`ifndef ASSERT_OFF
	a_accept_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted item did not enter stage 1");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !rdy_s2 |=> v_s1)
		else $error("stage 1 item dropped while blocked");

	a_bubble_fill: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !v_s3 |=> v_s3)
		else $error("stage 2 item did not advance into an empty output stage");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			res_s3[0] == vt4_pkg::COMP_MAX || res_s3[0] == vt4_pkg::COMP_MIN ||
			res_s3[1] == vt4_pkg::COMP_MAX || res_s3[1] == vt4_pkg::COMP_MIN ||
			res_s3[2] == vt4_pkg::COMP_MAX || res_s3[2] == vt4_pkg::COMP_MIN ||
			res_s3[3] == vt4_pkg::COMP_MAX || res_s3[3] == vt4_pkg::COMP_MIN)
		else $error("saturation flag set without a clamped component");
`endif

endmodule

// File: bench/vertex_transform_4x4_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_4x4_tb
// Self-checking bench for the 4x4 vertex transform.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the matrix and the transpose flag and
// computes each transformed vertex when the block accepts it. A checker on
// the output stream compares every result with the oldest pending one.
// Directed items cover the identity after reset, every register, stray
// register indexes, saturation both ways and floor rounding of negative
// products. Random items follow under several matrices and idle patterns,
// and a long output stall makes the pipeline fill and block its input.
// ----------------------------------------------------------------------------
module vertex_transform_4x4_tb;

	localparam logic [2:0] REG_INDEX_TOP = '1;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic         sat;
		logic [127:0] comps;
	} xform_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [63:0]  cfg_wdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// vertex_x [31:0], vertex_y [63:32], vertex_z [95:64], vertex_w [127:96]
	logic [127:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// out_x [31:0], out_y [63:32], out_z [95:64], out_w [127:96]
	logic [127:0] m_axis_tdata;
	// saturated [0]
	logic         m_axis_tuser;

	logic [63:0]  mat_row [4];
	logic         mat_transpose;
	xform_t       pending_xforms [$];
	int           mismatch_count = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;
	int           hold_req = 0;
	int           hold_seen = 0;
	int           hold_left = 0;

	vertex_transform_4x4 i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("vertex_transform_4x4_tb NOT OK");
		$finish;
	end

	function automatic xform_t transform_vertex(input logic [127:0] v);
		xform_t          r;
		longint          acc;
		vt4_pkg::coef_t  k;
		vt4_pkg::comp_t  c;
		int              i;
		int              j;
		r.sat = 1'b0;
		for (i = 0; i < 4; i++) begin
			acc = 0;
			for (j = 0; j < 4; j++) begin
				k = mat_transpose ? mat_row[j][16*i +: 16] : mat_row[i][16*j +: 16];
				c = v[32*j +: 32];
				acc += (longint'(k) * longint'(c)) >>> vt4_pkg::FRAC_DROP;
			end
			if (acc > longint'(vt4_pkg::COMP_MAX)) begin
				acc = longint'(vt4_pkg::COMP_MAX);
				r.sat = 1'b1;
			end else if (acc < longint'(vt4_pkg::COMP_MIN)) begin
				acc = longint'(vt4_pkg::COMP_MIN);
				r.sat = 1'b1;
			end
			r.comps[32*i +: 32] = acc[31:0];
		end
		return r;
	endfunction

	function automatic logic [127:0] make_vertex(input vt4_pkg::comp_t x,
			input vt4_pkg::comp_t y, input vt4_pkg::comp_t z, input vt4_pkg::comp_t w);
		return {w, z, y, x};
	endfunction

	function automatic vt4_pkg::comp_t random_comp();
		logic [31:0] t;
		t = $urandom;
		case ($urandom_range(3))
			0: return t;
			1: return {{12{t[19]}}, t[19:0]};
			2: begin
				case (t[1:0])
					2'd0: return vt4_pkg::COMP_MAX;
					2'd1: return vt4_pkg::COMP_MIN;
					2'd2: return '0;
					default: return '1;
				endcase
			end
			default: return {{8{t[23]}}, t[23:0]};
		endcase
	endfunction

	function automatic logic [127:0] random_vertex();
		return make_vertex(random_comp(), random_comp(), random_comp(), random_comp());
	endfunction

	function automatic logic [63:0] random_row(input int kind);
		logic [63:0] r;
		logic [15:0] t;
		int          j;
		for (j = 0; j < 4; j++) begin
			t = 16'($urandom);
			case (kind)
				0: r[16*j +: 16] = t;
				1: begin
					case ($urandom_range(4))
						0: r[16*j +: 16] = 16'h7FFF;
						1: r[16*j +: 16] = 16'h8000;
						2: r[16*j +: 16] = 16'h0000;
						3: r[16*j +: 16] = 16'hFFFF;
						default: r[16*j +: 16] = 16'h1000;
					endcase
				end
				default: r[16*j +: 16] = {{3{t[12]}}, t[12:0]};
			endcase
		end
		return r;
	endfunction

	task automatic check_result();
		xform_t e;
		int     i;
		if (pending_xforms.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %h sat %b",
				$time, m_axis_tdata, m_axis_tuser);
			mismatch_count++;
		end else begin
			e = pending_xforms.pop_front();
			for (i = 0; i < 4; i++) begin
				if (m_axis_tdata[32*i +: 32] !== e.comps[32*i +: 32]) begin
					$display("%0t: component %0d expected %h actual %h", $time, i,
						e.comps[32*i +: 32], m_axis_tdata[32*i +: 32]);
					mismatch_count++;
				end
			end
			if (m_axis_tuser !== e.sat) begin
				$display("%0t: saturated expected %b actual %b", $time, e.sat,
					m_axis_tuser);
				mismatch_count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			check_result();
		end
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic set_idle(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	task automatic send_vertex(input logic [127:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_xforms.push_back(transform_vertex(v));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_xforms.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx <= vt4_pkg::REG_ROW3) begin
			mat_row[idx[1:0]] = val;
		end else if (idx == vt4_pkg::REG_TRANSPOSE) begin
			mat_transpose = val[0];
		end
	endtask

	task automatic load_matrix(input logic [3:0][63:0] rows, input logic [63:0] tr);
		int i;
		drain();
		for (i = 0; i < 4; i++) begin
			write_reg(vt4_pkg::REG_ROW0 + 3'(i), rows[i]);
		end
		write_reg(vt4_pkg::REG_TRANSPOSE, tr);
	endtask

	task automatic test_reset_identity();
		send_vertex(make_vertex('0, '0, '0, '0));
		send_vertex(make_vertex(vt4_pkg::COMP_MAX, vt4_pkg::COMP_MAX, vt4_pkg::COMP_MAX,
			vt4_pkg::COMP_MAX));
		send_vertex(make_vertex(vt4_pkg::COMP_MIN, vt4_pkg::COMP_MIN, vt4_pkg::COMP_MIN,
			vt4_pkg::COMP_MIN));
		send_vertex(make_vertex(32'sd1, -32'sd1, vt4_pkg::COMP_MAX, vt4_pkg::COMP_MIN));
		send_vertex(make_vertex($urandom, $urandom, $urandom, $urandom));
	endtask

	task automatic test_config_regs();
		logic [3:0][63:0] rows;
		int               idx;
		rows[0] = {16'h0000, 16'hF800, 16'h0800, 16'h1000};
		rows[1] = {16'h7FFF, 16'h0001, 16'hE000, 16'h0400};
		rows[2] = {16'h8000, 16'h2000, 16'hFFFF, 16'h0C00};
		rows[3] = {16'h1000, 16'h0000, 16'h0100, 16'hF000};
		load_matrix(rows, '0);
		send_vertex(make_vertex(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000,
			32'sh0001_0000));
		send_vertex(random_vertex());
		drain();
		write_reg(vt4_pkg::REG_TRANSPOSE, 64'h1);
		send_vertex(make_vertex(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000,
			32'sh0001_0000));
		send_vertex(random_vertex());
		drain();
		// Indexes past the transpose flag must not disturb any register.
		for (idx = int'(vt4_pkg::REG_TRANSPOSE) + 1; idx <= int'(REG_INDEX_TOP);
				idx++) begin
			write_reg(3'(idx), {$urandom, $urandom});
		end
		write_reg(vt4_pkg::REG_TRANSPOSE, 64'hFFFF_FFFF_FFFF_FFFE);
		send_vertex(random_vertex());
		send_vertex(random_vertex());
		drain();
		write_reg(vt4_pkg::REG_TRANSPOSE, '1);
		send_vertex(random_vertex());
	endtask

	task automatic test_saturation_rounding();
		logic [3:0][63:0] rows;
		int               i;
		for (i = 0; i < 4; i++) rows[i] = {4{16'h7FFF}};
		load_matrix(rows, '0);
		send_vertex(make_vertex(vt4_pkg::COMP_MAX, vt4_pkg::COMP_MAX, vt4_pkg::COMP_MAX,
			vt4_pkg::COMP_MAX));
		send_vertex(make_vertex(vt4_pkg::COMP_MIN, vt4_pkg::COMP_MIN, vt4_pkg::COMP_MIN,
			vt4_pkg::COMP_MIN));
		for (i = 0; i < 4; i++) rows[i] = {4{16'h8000}};
		load_matrix(rows, '0);
		send_vertex(make_vertex(vt4_pkg::COMP_MAX, vt4_pkg::COMP_MAX, vt4_pkg::COMP_MAX,
			vt4_pkg::COMP_MAX));
		send_vertex(make_vertex(vt4_pkg::COMP_MIN, vt4_pkg::COMP_MIN, vt4_pkg::COMP_MIN,
			vt4_pkg::COMP_MIN));
		// The smallest coefficient times a small negative component must
		// round toward minus infinity.
		rows = '0;
		rows[0] = 64'h0000_0000_0000_0001;
		rows[1] = 64'h0000_0000_0001_0000;
		load_matrix(rows, '0);
		send_vertex(make_vertex(-32'sd1, 32'sd1, '0, '0));
		send_vertex(make_vertex(-32'sd4097, -32'sd4096, '0, '0));
	endtask

	task automatic test_random_stream();
		logic [3:0][63:0] rows;
		int               pass_no;
		int               n;
		int               i;
		for (pass_no = 0; pass_no < 6; pass_no++) begin
			for (i = 0; i < 4; i++) rows[i] = random_row(pass_no % 3);
			load_matrix(rows, {$urandom, $urandom});
			case (pass_no / 2)
				0: set_idle(28, 47);
				1: set_idle(47, 28);
				default: set_idle(0, 0);
			endcase
			for (n = 0; n < 150; n++) send_vertex(random_vertex());
		end
	endtask

	task automatic test_backpressure();
		int n;
		set_idle(0, 0);
		hold_req++;
		for (n = 0; n < 40; n++) send_vertex(random_vertex());
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= vt4_pkg::REG_ROW0;
		cfg_wdata     <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		mat_row[0]    = vt4_pkg::ROW0_RESET;
		mat_row[1]    = vt4_pkg::ROW1_RESET;
		mat_row[2]    = vt4_pkg::ROW2_RESET;
		mat_row[3]    = vt4_pkg::ROW3_RESET;
		mat_transpose = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_identity();
		test_config_regs();
		test_saturation_rounding();
		test_random_stream();
		test_backpressure();
		drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("vertex_transform_4x4_tb OK");
		end else begin
			$display("vertex_transform_4x4_tb NOT OK");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/vt4_pkg.sv
sv/vt4_dot4.sv
sv/vertex_transform_4x4.sv
bench/vertex_transform_4x4_tb.sv
